// ===== design/cgrp_pkg.sv =====
// Shared types and constants for the composite glyph record parser.
`timescale 1ns / 1ps

package cgrp_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_COMPONENT = 2'd0;
  localparam logic [1:0] KIND_ILEN      = 2'd1;
  localparam logic [1:0] KIND_IBYTE     = 2'd2;

  // Component flag bits, as published for composite glyphs.
  localparam int unsigned FLG_WORDS_BIT = 0;
  localparam int unsigned FLG_SCALE_BIT = 3;
  localparam int unsigned FLG_MORE_BIT  = 5;
  localparam int unsigned FLG_XY_BIT    = 6;
  localparam int unsigned FLG_2X2_BIT   = 7;
  localparam int unsigned FLG_INSTR_BIT = 8;

  // One in 2.14 fixed point.
  localparam logic [15:0] ONE_2DOT14 = 16'h4000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] comp_flags;
    logic [15:0] comp_glyph;
    logic [15:0] arg_one;
    logic [15:0] arg_two;
    logic [15:0] xx_scale;
    logic [15:0] xy_scale;
    logic [15:0] yx_scale;
    logic [15:0] yy_scale;
    logic [15:0] instr_length;
    logic [7:0]  instr_byte;
    logic        glyph_end;
  } result_t;

endpackage

// ===== design/cgrp_parser.sv =====
// Byte-stream parser state machine that builds component and instruction results.
`timescale 1ns / 1ps

module cgrp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              start_glyph,
  output logic              res_valid,
  output cgrp_pkg::result_t res
);

  localparam logic [3:0] PH_FLAGS_HI = 4'd0;
  localparam logic [3:0] PH_FLAGS_LO = 4'd1;
  localparam logic [3:0] PH_INDEX_HI = 4'd2;
  localparam logic [3:0] PH_INDEX_LO = 4'd3;
  localparam logic [3:0] PH_ARGS     = 4'd4;
  localparam logic [3:0] PH_XFORM    = 4'd5;
  localparam logic [3:0] PH_ILEN_HI  = 4'd6;
  localparam logic [3:0] PH_ILEN_LO  = 4'd7;
  localparam logic [3:0] PH_IBYTES   = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  logic [3:0]  phase_r, phase_nxt, phase_eff;
  logic [2:0]  cnt_r, cnt_nxt, cnt_eff;
  logic [3:0]  cnt_inc;
  logic [15:0] flags_r, flags_nxt;
  logic [15:0] index_r, index_nxt;
  logic [15:0] arg_r [2];
  logic [15:0] arg_nxt [2];
  logic [15:0] xf_r [4];
  logic [15:0] xf_nxt [4];
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] word;
  logic [3:0]  xbytes;
  logic        finish;

  assign word    = {hold_r, data_byte};
  assign cnt_eff = start_glyph ? 3'd0 : cnt_r;
  assign cnt_inc = {1'b0, cnt_eff} + 4'd1;

  always_comb begin
    if (flags_r[cgrp_pkg::FLG_SCALE_BIT]) begin
      xbytes = 4'd2;
    end else if (flags_r[cgrp_pkg::FLG_XY_BIT]) begin
      xbytes = 4'd4;
    end else if (flags_r[cgrp_pkg::FLG_2X2_BIT]) begin
      xbytes = 4'd8;
    end else begin
      xbytes = 4'd0;
    end
  end

  always_comb begin
    phase_eff = start_glyph ? PH_FLAGS_HI : phase_r;
    phase_nxt = phase_eff;
    cnt_nxt   = cnt_eff;
    flags_nxt = flags_r;
    index_nxt = index_r;
    arg_nxt   = arg_r;
    xf_nxt    = xf_r;
    hold_nxt  = hold_r;
    rem_nxt   = rem_r;
    finish    = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_eff)
      PH_FLAGS_HI: begin
        hold_nxt   = data_byte;
        xf_nxt[0]  = cgrp_pkg::ONE_2DOT14;
        xf_nxt[1]  = '0;
        xf_nxt[2]  = '0;
        xf_nxt[3]  = cgrp_pkg::ONE_2DOT14;
        arg_nxt[0] = '0;
        arg_nxt[1] = '0;
        phase_nxt  = PH_FLAGS_LO;
      end
      PH_FLAGS_LO: begin
        flags_nxt = word;
        phase_nxt = PH_INDEX_HI;
      end
      PH_INDEX_HI: begin
        hold_nxt  = data_byte;
        phase_nxt = PH_INDEX_LO;
      end
      PH_INDEX_LO: begin
        index_nxt = word;
        cnt_nxt   = 3'd0;
        phase_nxt = PH_ARGS;
      end
      PH_ARGS: begin
        cnt_nxt = cnt_inc[2:0];
        if (flags_r[cgrp_pkg::FLG_WORDS_BIT]) begin
          if (!cnt_eff[0]) begin
            hold_nxt = data_byte;
          end else begin
            arg_nxt[cnt_eff[1]] = word;
          end
          if (cnt_inc >= 4'd4) begin
            cnt_nxt = 3'd0;
            if (xbytes == 4'd0) begin
              finish = 1'b1;
            end else begin
              phase_nxt = PH_XFORM;
            end
          end
        end else begin
          arg_nxt[cnt_eff[0]] = {{8{data_byte[7]}}, data_byte};
          if (cnt_inc >= 4'd2) begin
            cnt_nxt = 3'd0;
            if (xbytes == 4'd0) begin
              finish = 1'b1;
            end else begin
              phase_nxt = PH_XFORM;
            end
          end
        end
      end
      PH_XFORM: begin
        cnt_nxt = cnt_inc[2:0];
        if (!cnt_eff[0]) begin
          hold_nxt = data_byte;
        end else begin
          if (flags_r[cgrp_pkg::FLG_SCALE_BIT]) begin
            xf_nxt[0] = word;
            xf_nxt[3] = word;
          end else if (flags_r[cgrp_pkg::FLG_XY_BIT]) begin
            if (cnt_eff[2:1] == 2'd0) begin
              xf_nxt[0] = word;
            end else begin
              xf_nxt[3] = word;
            end
          end else begin
            xf_nxt[cnt_eff[2:1]] = word;
          end
          if (cnt_inc >= xbytes) begin
            cnt_nxt = 3'd0;
            finish  = 1'b1;
          end
        end
      end
      PH_ILEN_HI: begin
        hold_nxt  = data_byte;
        phase_nxt = PH_ILEN_LO;
      end
      PH_ILEN_LO: begin
        rem_nxt          = word;
        res_valid        = 1'b1;
        res.kind         = cgrp_pkg::KIND_ILEN;
        res.instr_length = word;
        if (word == 16'd0) begin
          phase_nxt     = PH_DONE;
          res.glyph_end = 1'b1;
        end else begin
          phase_nxt = PH_IBYTES;
        end
      end
      PH_IBYTES: begin
        rem_nxt        = rem_r - 16'd1;
        res_valid      = 1'b1;
        res.kind       = cgrp_pkg::KIND_IBYTE;
        res.instr_byte = data_byte;
        if (rem_r == 16'd1) begin
          phase_nxt     = PH_DONE;
          res.glyph_end = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // A component record reports the registers as they stand after this byte.
    if (finish) begin
      res_valid       = 1'b1;
      res.kind        = cgrp_pkg::KIND_COMPONENT;
      res.comp_flags  = flags_r;
      res.comp_glyph  = index_r;
      res.arg_one     = arg_nxt[0];
      res.arg_two     = arg_nxt[1];
      res.xx_scale    = xf_nxt[0];
      res.xy_scale    = xf_nxt[1];
      res.yx_scale    = xf_nxt[2];
      res.yy_scale    = xf_nxt[3];
      if (flags_r[cgrp_pkg::FLG_MORE_BIT]) begin
        phase_nxt = PH_FLAGS_HI;
      end else if (flags_r[cgrp_pkg::FLG_INSTR_BIT]) begin
        phase_nxt = PH_ILEN_HI;
      end else begin
        phase_nxt     = PH_DONE;
        res.glyph_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FLAGS_HI;
      cnt_r    <= '0;
      flags_r  <= '0;
      index_r  <= '0;
      arg_r[0] <= '0;
      arg_r[1] <= '0;
      xf_r[0]  <= cgrp_pkg::ONE_2DOT14;
      xf_r[1]  <= '0;
      xf_r[2]  <= '0;
      xf_r[3]  <= cgrp_pkg::ONE_2DOT14;
      hold_r   <= '0;
      rem_r    <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
      index_r <= index_nxt;
      arg_r   <= arg_nxt;
      xf_r    <= xf_nxt;
      hold_r  <= hold_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ===== design/composite_glyph_record_parser_core.sv =====
// Top level of the composite glyph record parser: byte input, registered result output.
// A result is registered and is presented in the cycle after the byte that completes it.
// Throughput: one input word per cycle; a byte is held off only while a result waits
// in the output register and the receiver stalls it.
// Reset (synchronous, active low) returns the parser to waiting for a flags high byte,
// loads the identity transform and empties the output register.
`timescale 1ns / 1ps

module composite_glyph_record_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_start_glyph,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_comp_flags,
  output logic [15:0]        out_comp_glyph,
  output logic signed [15:0] out_arg_one,
  output logic signed [15:0] out_arg_two,
  output logic signed [15:0] out_xx_scale,
  output logic signed [15:0] out_xy_scale,
  output logic signed [15:0] out_yx_scale,
  output logic signed [15:0] out_yy_scale,
  output logic [15:0]        out_instr_length,
  output logic [7:0]         out_instr_byte,
  output logic               out_glyph_end
);

  logic              take;
  logic              res_valid;
  cgrp_pkg::result_t res;
  logic              out_valid_r, out_valid_nxt;
  cgrp_pkg::result_t out_r;

  // The input side is held off only when the output register is full and its
  // word is not leaving this cycle; every other byte enters at once.
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  cgrp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .data_byte   (in_data_byte),
    .start_glyph (in_start_glyph),
    .res_valid   (res_valid),
    .res         (res)
  );

  // The output register is loaded whenever a taken byte gives a result; a taken byte
  // with no result leaves it empty, and without a take it empties unless stalled.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_r.kind;
  assign out_comp_flags   = out_r.comp_flags;
  assign out_comp_glyph   = out_r.comp_glyph;
  assign out_arg_one      = $signed(out_r.arg_one);
  assign out_arg_two      = $signed(out_r.arg_two);
  assign out_xx_scale     = $signed(out_r.xx_scale);
  assign out_xy_scale     = $signed(out_r.xy_scale);
  assign out_yx_scale     = $signed(out_r.yx_scale);
  assign out_yy_scale     = $signed(out_r.yy_scale);
  assign out_instr_length = out_r.instr_length;
  assign out_instr_byte   = out_r.instr_byte;
  assign out_glyph_end    = out_r.glyph_end;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the composite glyph record parser core.
`timescale 1ns / 1ps

module tb_top;
  import cgrp_pkg::*;

  // Parser phases tracked by the prediction code. These mirror the stages of a
  // composite glyph description: flags, glyph index, arguments, optional
  // transform, then the instruction length and the instruction bytes.
  typedef enum logic [3:0] {
    PH_FLAGS_HI,
    PH_FLAGS_LO,
    PH_INDEX_HI,
    PH_INDEX_LO,
    PH_ARGS,
    PH_XFORM,
    PH_ILEN_HI,
    PH_ILEN_LO,
    PH_IBYTES,
    PH_DONE
  } parse_phase_t;

  // One input word waiting to be offered to the block.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_start_glyph = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic [15:0]        out_comp_flags;
  logic [15:0]        out_comp_glyph;
  logic signed [15:0] out_arg_one;
  logic signed [15:0] out_arg_two;
  logic signed [15:0] out_xx_scale;
  logic signed [15:0] out_xy_scale;
  logic signed [15:0] out_yx_scale;
  logic signed [15:0] out_yy_scale;
  logic [15:0]        out_instr_length;
  logic [7:0]         out_instr_byte;
  logic               out_glyph_end;

  // Bytes still to be offered, and records the parser is predicted to emit.
  stream_byte_t byte_stream_q[$];
  result_t      predicted_records[$];

  // Idle and stall percentages for the current phase of the run.
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Long receiver hold-off: the stimulus block raises the request count, the
  // stall process notices the change and counts the stretch down by itself.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int mismatch_count = 0;

  // Shadow copy of the parser state used for prediction.
  parse_phase_t parse_phase = PH_FLAGS_HI;
  logic [3:0]   byte_cnt = '0;
  logic [15:0]  flags_reg = '0;
  logic [15:0]  index_reg = '0;
  logic [15:0]  arg_val[2] = '{16'h0000, 16'h0000};
  logic [15:0]  xform[4] = '{ONE_2DOT14, 16'h0000, 16'h0000, ONE_2DOT14};
  logic [7:0]   high_hold = '0;
  logic [15:0]  instr_left = '0;

  composite_glyph_record_parser_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_glyph   (in_start_glyph),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_comp_flags   (out_comp_flags),
    .out_comp_glyph   (out_comp_glyph),
    .out_arg_one      (out_arg_one),
    .out_arg_two      (out_arg_two),
    .out_xx_scale     (out_xx_scale),
    .out_xy_scale     (out_xy_scale),
    .out_yx_scale     (out_yx_scale),
    .out_yy_scale     (out_yy_scale),
    .out_instr_length (out_instr_length),
    .out_instr_byte   (out_instr_byte),
    .out_glyph_end    (out_glyph_end)
  );

  always #5 clk = ~clk;

  // Number of transform bytes the current flags call for. A uniform scale
  // takes priority over an x/y scale, which takes priority over a 2x2 matrix.
  function automatic int unsigned transform_len(input logic [15:0] f);
    if (f[FLG_SCALE_BIT]) return 2;
    if (f[FLG_XY_BIT]) return 4;
    if (f[FLG_2X2_BIT]) return 8;
    return 0;
  endfunction

  // Builds the component record from the collected registers and decides
  // where the stream goes next: another component, the instruction length,
  // or the end of the glyph.
  task automatic close_component(output result_t rec);
    rec = '0;
    rec.kind        = KIND_COMPONENT;
    rec.comp_flags  = flags_reg;
    rec.comp_glyph  = index_reg;
    rec.arg_one     = arg_val[0];
    rec.arg_two     = arg_val[1];
    rec.xx_scale    = xform[0];
    rec.xy_scale    = xform[1];
    rec.yx_scale    = xform[2];
    rec.yy_scale    = xform[3];
    if (flags_reg[FLG_MORE_BIT]) begin
      parse_phase = PH_FLAGS_HI;
    end else if (flags_reg[FLG_INSTR_BIT]) begin
      parse_phase = PH_ILEN_HI;
    end else begin
      parse_phase   = PH_DONE;
      rec.glyph_end = 1'b1;
    end
  endtask

  // Advances the shadow parser by one accepted byte and reports whether the
  // byte completes a record, and which.
  task automatic parse_byte(input logic [7:0] b, input logic start,
                            output bit emitted, output result_t rec);
    logic [15:0] word;
    bit          args_done;
    emitted = 1'b0;
    rec     = '0;
    // A start mark drops whatever was in progress.
    if (start) begin
      parse_phase = PH_FLAGS_HI;
      byte_cnt    = '0;
    end
    case (parse_phase)
      PH_FLAGS_HI: begin
        high_hold   = b;
        xform       = '{ONE_2DOT14, 16'h0000, 16'h0000, ONE_2DOT14};
        arg_val     = '{16'h0000, 16'h0000};
        parse_phase = PH_FLAGS_LO;
      end
      PH_FLAGS_LO: begin
        flags_reg   = {high_hold, b};
        parse_phase = PH_INDEX_HI;
      end
      PH_INDEX_HI: begin
        high_hold   = b;
        parse_phase = PH_INDEX_LO;
      end
      PH_INDEX_LO: begin
        index_reg   = {high_hold, b};
        byte_cnt    = '0;
        parse_phase = PH_ARGS;
      end
      PH_ARGS: begin
        if (flags_reg[FLG_WORDS_BIT]) begin
          if (!byte_cnt[0]) high_hold = b;
          else arg_val[byte_cnt[1]] = {high_hold, b};
          byte_cnt  = byte_cnt + 1'b1;
          args_done = (byte_cnt == 4'd4);
        end else begin
          // Byte arguments are sign-extended to a full word.
          arg_val[byte_cnt[0]] = {{8{b[7]}}, b};
          byte_cnt  = byte_cnt + 1'b1;
          args_done = (byte_cnt == 4'd2);
        end
        if (args_done) begin
          byte_cnt = '0;
          if (transform_len(flags_reg) == 0) begin
            close_component(rec);
            emitted = 1'b1;
          end else begin
            parse_phase = PH_XFORM;
          end
        end
      end
      PH_XFORM: begin
        if (!byte_cnt[0]) begin
          high_hold = b;
          byte_cnt  = byte_cnt + 1'b1;
        end else begin
          word = {high_hold, b};
          if (flags_reg[FLG_SCALE_BIT]) begin
            xform[0] = word;
            xform[3] = word;
          end else if (flags_reg[FLG_XY_BIT]) begin
            if (byte_cnt[2:1] == 2'd0) xform[0] = word;
            else xform[3] = word;
          end else begin
            xform[byte_cnt[2:1]] = word;
          end
          byte_cnt = byte_cnt + 1'b1;
          if (byte_cnt == transform_len(flags_reg)) begin
            byte_cnt = '0;
            close_component(rec);
            emitted = 1'b1;
          end
        end
      end
      PH_ILEN_HI: begin
        high_hold   = b;
        parse_phase = PH_ILEN_LO;
      end
      PH_ILEN_LO: begin
        instr_left       = {high_hold, b};
        emitted          = 1'b1;
        rec.kind         = KIND_ILEN;
        rec.instr_length = instr_left;
        // An empty instruction stream ends the glyph on the length record.
        if (instr_left == 16'd0) begin
          parse_phase   = PH_DONE;
          rec.glyph_end = 1'b1;
        end else begin
          parse_phase = PH_IBYTES;
        end
      end
      PH_IBYTES: begin
        emitted        = 1'b1;
        rec.kind       = KIND_IBYTE;
        rec.instr_byte = b;
        instr_left     = instr_left - 1'b1;
        if (instr_left == 16'd0) begin
          parse_phase   = PH_DONE;
          rec.glyph_end = 1'b1;
        end
      end
      default: begin
        // Bytes after the end of a glyph are dropped until a start mark.
        parse_phase = PH_DONE;
      end
    endcase
  endtask

  // Lists the fields of a record that differ from the prediction.
  function automatic string field_diffs(input result_t exp_r, input result_t got_r);
    string s;
    s = "";
    if (got_r.kind !== exp_r.kind)
      s = {s, $sformatf(" kind exp %0d got %0d", exp_r.kind, got_r.kind)};
    if (got_r.comp_flags !== exp_r.comp_flags)
      s = {s, $sformatf(" flags exp %h got %h", exp_r.comp_flags, got_r.comp_flags)};
    if (got_r.comp_glyph !== exp_r.comp_glyph)
      s = {s, $sformatf(" index exp %h got %h", exp_r.comp_glyph, got_r.comp_glyph)};
    if (got_r.arg_one !== exp_r.arg_one)
      s = {s, $sformatf(" arg1 exp %0d got %0d",
                        $signed(exp_r.arg_one), $signed(got_r.arg_one))};
    if (got_r.arg_two !== exp_r.arg_two)
      s = {s, $sformatf(" arg2 exp %0d got %0d",
                        $signed(exp_r.arg_two), $signed(got_r.arg_two))};
    if (got_r.xx_scale !== exp_r.xx_scale)
      s = {s, $sformatf(" xx exp %h got %h", exp_r.xx_scale, got_r.xx_scale)};
    if (got_r.xy_scale !== exp_r.xy_scale)
      s = {s, $sformatf(" xy exp %h got %h", exp_r.xy_scale, got_r.xy_scale)};
    if (got_r.yx_scale !== exp_r.yx_scale)
      s = {s, $sformatf(" yx exp %h got %h", exp_r.yx_scale, got_r.yx_scale)};
    if (got_r.yy_scale !== exp_r.yy_scale)
      s = {s, $sformatf(" yy exp %h got %h", exp_r.yy_scale, got_r.yy_scale)};
    if (got_r.instr_length !== exp_r.instr_length)
      s = {s, $sformatf(" ilen exp %0d got %0d", exp_r.instr_length, got_r.instr_length)};
    if (got_r.instr_byte !== exp_r.instr_byte)
      s = {s, $sformatf(" ibyte exp %h got %h", exp_r.instr_byte, got_r.instr_byte)};
    if (got_r.glyph_end !== exp_r.glyph_end)
      s = {s, $sformatf(" end exp %b got %b", exp_r.glyph_end, got_r.glyph_end)};
    return s;
  endfunction

  // Input driver. A word that is stalled stays on the bus untouched; once it
  // has been taken, the next one is offered or the sender idles instead.
  // Every accepted word is fed to the prediction right away.
  always @(posedge clk) begin : drive_input
    bit           emitted;
    result_t      rec;
    stream_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_data_byte, in_start_glyph, emitted, rec);
        if (emitted) predicted_records.push_back(rec);
      end
      if (!in_valid || !in_stall) begin
        if (byte_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_stream_q.pop_front();
          in_valid       <= 1'b1;
          in_data_byte   <= nxt.data;
          in_start_glyph <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Each record taken from the block is checked against the
  // oldest prediction; a record that nobody predicted is a failure too.
  always @(posedge clk) begin : check_output
    result_t got_r;
    result_t exp_r;
    string   diffs;
    if (rst_n && out_valid && !out_stall) begin
      got_r = {out_kind, out_comp_flags, out_comp_glyph, out_arg_one, out_arg_two,
               out_xx_scale, out_xy_scale, out_yx_scale, out_yy_scale,
               out_instr_length, out_instr_byte, out_glyph_end};
      if (predicted_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected record kind %0d flags %h end %b", $realtime,
                   got_r.kind, got_r.comp_flags, got_r.glyph_end);
      end else begin
        exp_r = predicted_records.pop_front();
        diffs = field_diffs(exp_r, got_r);
        if (diffs != "") begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("%0t: record mismatch:%s", $realtime, diffs);
        end
      end
    end
  end

  // Receiver stall. A pending hold-off request takes priority over the
  // random stall of the current phase.
  always @(posedge clk) begin : drive_stall
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic start);
    stream_byte_t it;
    it.data  = data;
    it.start = start;
    byte_stream_q.push_back(it);
  endtask

  // Queues one random composite glyph. Most glyphs are complete; some are
  // cut short (the next glyph's start mark then abandons them) and some are
  // followed by stray bytes that the block must ignore. Returns the number
  // of glyph bytes queued, stray bytes not included.
  task automatic add_random_glyph(output int queued);
    logic [7:0]  body[$];
    logic [15:0] flags;
    logic [15:0] ilen;
    int          ncomp;
    int          nbytes;
    int          c;
    int          k;
    int          shape;
    ncomp = $urandom_range(1, 3);
    flags = '0;
    for (c = 0; c < ncomp; c++) begin
      flags = 16'($urandom);
      // Usually pick at most one transform form; otherwise leave the random mix so
      // that the priority between several transform flags gets exercised.
      if ($urandom_range(3) != 0) begin
        flags[FLG_SCALE_BIT] = 1'b0;
        flags[FLG_XY_BIT]    = 1'b0;
        flags[FLG_2X2_BIT]   = 1'b0;
        case ($urandom_range(3))
          1: flags[FLG_SCALE_BIT] = 1'b1;
          2: flags[FLG_XY_BIT]    = 1'b1;
          3: flags[FLG_2X2_BIT]   = 1'b1;
          default: ;
        endcase
      end
      flags[FLG_MORE_BIT] = (c != ncomp - 1);
      body.push_back(flags[15:8]);
      body.push_back(flags[7:0]);
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      nbytes = (flags[FLG_WORDS_BIT] ? 4 : 2) + transform_len(flags);
      for (k = 0; k < nbytes; k++) body.push_back(8'($urandom));
    end
    if (flags[FLG_INSTR_BIT]) begin
      ilen = ($urandom_range(19) == 0) ? 16'($urandom_range(300)) :
                                         16'($urandom_range(6));
      body.push_back(ilen[15:8]);
      body.push_back(ilen[7:0]);
      for (k = 0; k < ilen; k++) body.push_back(8'($urandom));
    end
    shape = $urandom_range(9);
    if (shape == 0) begin
      nbytes = $urandom_range(1, body.size() - 1);
      while (body.size() > nbytes) void'(body.pop_back());
    end
    queued = body.size();
    for (k = 0; k < body.size(); k++) push_byte(body[k], k == 0);
    if (shape == 1) begin
      nbytes = $urandom_range(1, 4);
      for (k = 0; k < nbytes; k++) push_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic add_random_bytes(input int target);
    int done_bytes;
    int n;
    done_bytes = 0;
    while (done_bytes < target) begin
      add_random_glyph(n);
      done_bytes += n;
    end
  endtask

  // Waits at falling edges until every queued word has been taken and every
  // predicted record has come out.
  task automatic wait_drained();
    while (byte_stream_q.size() != 0 || in_valid || predicted_records.size() != 0)
      @(negedge clk);
  endtask

  // Main sequence: reset, directed glyphs, a long output hold-off, then
  // random glyphs under each idling pattern.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest glyph: byte arguments at both sign extremes, largest index,
    // no transform, no instructions.
    push_byte(8'h00, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b0);
    // A stray byte after the end of the glyph is ignored.
    push_byte(8'h55, 1'b0);
    // Word arguments at the extremes, every transform flag set so that the
    // uniform scale wins, then an empty instruction stream.
    push_byte(8'h01, 1'b1); push_byte(8'hC9, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hC0, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    // Two components: x/y scale wins over the matrix in the first, the full
    // matrix and two instruction bytes in the second.
    push_byte(8'h00, 1'b1); push_byte(8'hE0, 1'b0);
    push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h40, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hC0, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    // Largest instruction length, abandoned after one instruction byte by
    // the start mark of the next glyph.
    push_byte(8'h01, 1'b1); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hAB, 1'b0);
    // The sender pauses here until every record has come out.
    wait_drained();

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the output register fills and the input stalls.
    hold_requests++;
    add_random_bytes(120);
    wait_drained();

    send_idle_pct = 0;  stall_pct = 0;  add_random_bytes(220); wait_drained();
    send_idle_pct = 55; stall_pct = 0;  add_random_bytes(220); wait_drained();
    send_idle_pct = 0;  stall_pct = 55; add_random_bytes(220); wait_drained();
    send_idle_pct = 32; stall_pct = 32; add_random_bytes(220); wait_drained();

    // Results are registered from the completing word; the extra wait below
    // lets anything unpredicted show up.
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && predicted_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
